// ===== rtl/iss_pkg.sv =====
// ----------------------------------------------------------------------------
// iss_pkg: shared types and constants for the indexed sequence store
// Request kinds, status codes, field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package iss_pkg;

   localparam int WORD_W  = 32;
   localparam int MODE_W  = 3;
   localparam int POS_W   = 5;
   localparam int FOUND_W = 5;
   localparam int COUNT_W = 5;

   localparam logic [FOUND_W-1:0] NO_MATCH = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_GET    = 3'd0,
      MODE_APPEND = 3'd1,
      MODE_DROP   = 3'd2,
      MODE_FIND   = 3'd3,
      MODE_INSERT = 3'd4,
      MODE_REMOVE = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // What one cell does with its entry at the next clock edge.
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LEFT  = 2'd2,
      CELL_FROM_RIGHT = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        live;   // cell lies below the entry count
      logic        pick;   // cell sits at the requested position
   } cell_ctl_type;

endpackage

// ===== rtl/iss_cell.sv =====
// ----------------------------------------------------------------------------
// iss_cell: one entry of the sequence store
// Holds one word, takes a new word or a neighbor's word, and reports a key
// match and its read contribution.
// ----------------------------------------------------------------------------
module iss_cell
   import iss_pkg::*;
(
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [WORD_W-1:0] word,
   input  logic [WORD_W-1:0] left_value,
   input  logic [WORD_W-1:0] right_value,
   output logic [WORD_W-1:0] value,
   output logic              match,
   output logic [WORD_W-1:0] read_part
);

   logic [WORD_W-1:0] value_ff;
   logic [WORD_W-1:0] value_in;

   always_comb begin
      case (ctl.op)
         CELL_LOAD:       value_in = word;
         CELL_FROM_LEFT:  value_in = left_value;
         CELL_FROM_RIGHT: value_in = right_value;
         default:         value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign match     = ctl.live && (value_ff == word);
   assign read_part = (ctl.live && ctl.pick) ? value_ff : '0;

endmodule

// ===== rtl/indexed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store: bounded ordered list of signed 32-bit entries
// A row of cells, one entry each, serving get, append, drop, find, insert
// and remove requests with one response per request.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ stream. The kind of request travels in
// req_tuser; the position and the data word travel in req_tdata. Every
// accepted item produces exactly one response item on the rsp_ stream, with
// the status in rsp_tuser and the value read, the position found and the new
// entry count in rsp_tdata.
// All cells compare, shift and read in parallel, so a request is decoded,
// applied to the row and its response registered in the cycle it is
// accepted. The response appears in the cycle after acceptance and the block
// takes one item per cycle; the single response register sets that rate.
// When the receiver stalls, the response register holds its item and
// req_tready drops until the item is taken; a new request is accepted in the
// same cycle that the pending response is taken.
// Reset clears the entry count and the response valid flag. Entry contents
// are not cleared; only entries below the count are ever read.
// Insert shifts the later entries up by one cell, remove shifts them down.
// ----------------------------------------------------------------------------
module indexed_sequence_store
   import iss_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position [4:0], data_word [36:5], zero pad
   input  logic [2:0]  req_tuser,   // mode [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // read_value [31:0], found_at [36:32],
                                    // entry_count [41:37], zero pad
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   // Count width holds DEPTH itself; comparisons run at the wider of the
   // count and the position field.
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   status_type    status_ff;
   status_type    status_in;
   logic [WORD_W-1:0]  read_ff;
   logic [WORD_W-1:0]  read_in;
   logic [FOUND_W-1:0] found_ff;
   logic [FOUND_W-1:0] found_in;
   logic [COUNT_W-1:0] count_out_ff;

   logic              req_accept;
   mode_type          mode;
   logic [POS_W-1:0]  position;
   logic [WORD_W-1:0] data_word;
   logic [PW-1:0]     pos_x;
   logic [PW-1:0]     cnt_x;
   logic              full;

   cell_ctl_type      cell_ctl   [DEPTH];
   logic [WORD_W-1:0] cell_value [DEPTH];
   logic [WORD_W-1:0] cell_read  [DEPTH];
   logic [DEPTH-1:0]  cell_match;

   assign mode      = mode_type'(req_tuser);
   assign position  = req_tdata[POS_W-1:0];
   assign data_word = req_tdata[POS_W+WORD_W-1:POS_W];
   assign pos_x     = PW'(position);
   assign cnt_x     = PW'(cnt_ff);
   assign full      = (cnt_ff == CW'(DEPTH));

   // The response register frees up as soon as its item is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Request decode: status and next count.
   always_comb begin
      status_in = STATUS_OK;
      cnt_in    = cnt_ff;
      case (mode)
         MODE_GET: begin
            if (pos_x >= cnt_x) status_in = STATUS_RANGE;
         end
         MODE_APPEND: begin
            if (full) status_in = STATUS_FULL;
            else cnt_in = cnt_ff + CW'(1);
         end
         MODE_DROP: begin
            if (cnt_ff != '0) cnt_in = cnt_ff - CW'(1);
         end
         MODE_INSERT: begin
            if (pos_x > cnt_x) status_in = STATUS_RANGE;
            else if (full) status_in = STATUS_FULL;
            else cnt_in = cnt_ff + CW'(1);
         end
         MODE_REMOVE: begin
            if (pos_x >= cnt_x) status_in = STATUS_RANGE;
            else cnt_in = cnt_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   // Per-cell control: each cell sees its own load or shift command. State
   // only changes on an accepted request that succeeded.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctl[i].live = (PW'(i) < cnt_x);
         cell_ctl[i].pick = (PW'(i) == pos_x);
         cell_ctl[i].op   = CELL_HOLD;
         if (req_accept && status_in == STATUS_OK) begin
            case (mode)
               MODE_APPEND: begin
                  if (PW'(i) == cnt_x) cell_ctl[i].op = CELL_LOAD;
               end
               MODE_INSERT: begin
                  if (PW'(i) == pos_x) cell_ctl[i].op = CELL_LOAD;
                  else if (PW'(i) > pos_x) cell_ctl[i].op = CELL_FROM_LEFT;
               end
               MODE_REMOVE: begin
                  if (PW'(i) >= pos_x && i < DEPTH - 1) cell_ctl[i].op = CELL_FROM_RIGHT;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // The row of cells; each hands its entry to both neighbors.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] left_value;
      logic [WORD_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_inner_right
         assign right_value = cell_value[g+1];
      end

      iss_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[g]),
         .word        (data_word),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[g]),
         .match       (cell_match[g]),
         .read_part   (cell_read[g])
      );
   end

   // Read: at most one live cell is picked, so the contributions are OR-ed.
   // Find: the lowest matching cell wins.
   always_comb begin
      read_in  = '0;
      found_in = NO_MATCH;
      for (int i = 0; i < DEPTH; i++) begin
         read_in = read_in | cell_read[i];
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i]) found_in = FOUND_W'(i);
      end
      if (mode != MODE_GET) read_in = '0;
      if (mode != MODE_FIND) found_in = NO_MATCH;
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff    <= status_in;
         read_ff      <= read_in;
         found_ff     <= found_in;
         count_out_ff <= COUNT_W'(cnt_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {6'd0, count_out_ff, found_ff, read_ff};

   // The count never passes the capacity of the row.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   // The count only moves when a request is accepted.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(cnt_ff))
      else $error("entry count changed without a request");

   // Every accepted request leaves a response pending.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request without response");

   // A full status is only reported while the row is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_FULL) |-> full)
      else $error("full status with free cells");

endmodule
